>>> rtl/mts_pkg.sv
// Package for the minimum-tracking stack: widths, request and status codes,
// and the command bundle that the controller sends to the datapath.
// No dependencies; every other file of the block imports it.
package mts_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ENTRY_W    = DATA_WIDTH + 2;
    localparam int PTR_W      = $clog2(DEPTH + 1);
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;

    // Result payload without padding, then rounded up to whole bytes.
    localparam int RES_W    = 3 * DATA_WIDTH + PTR_W + 1;
    localparam int TDATA_W  = ((RES_W + 7) / 8) * 8;
    localparam int S_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;    // apply the accepted request to the stack state
        logic finish;  // refill the cached top and load the result register
    } mts_cmd_t;

endpackage

>>> rtl/min_tracking_stack_top.sv
// Top level of the minimum-tracking stack: stream ports, controller and
// datapath. Depends on mts_pkg, mts_ctrl and mts_datapath.
//
//   Channel  Direction  Transaction contents
//   s_       in         s_tuser: req_type; s_tdata: value
//   m_       out        m_tdata: popped_value, top_value, min_value,
//                       entry_count, is_empty; m_tuser: status
//
// Each request is accepted in the idle state, which applies the request to
// the stack pointer, the minimum and the entry memory; the refill state then
// moves the entry read from the memory port into the cached top and loads
// the result register. The single read port of the entry memory sets that
// refill state. A new request is taken while a finished result waits on the
// master side; the block only holds in its refill state while that result
// is still not taken. Reset is synchronous and active low; it empties the
// stack and clears the minimum, while the entry memory keeps its contents.
module min_tracking_stack_top
    import mts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // value
    input  logic [REQ_W-1:0]      s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // popped_value, top_value, min_value, entry_count, is_empty, zero padding
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    mts_cmd_t cmd;

    // The controller sequences each transaction and owns the result-valid flag.
    mts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the stack state and the result register.
    mts_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .req_type   (s_tuser),
        .value      (s_tdata[DATA_WIDTH-1:0]),
        .res_data   (m_tdata),
        .res_status (m_tuser)
    );

endmodule

>>> rtl/mts_ctrl.sv
// Controller of the minimum-tracking stack: a two-state sequencer and the
// result-valid flag. Depends on mts_pkg.
module mts_ctrl
    import mts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output mts_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REFILL = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.exec   = s_tready && s_tvalid;
    assign cmd.finish = (state_reg == ST_REFILL) && out_free;
    assign m_tvalid   = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_REFILL;
                end
            end
            ST_REFILL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> rtl/mts_datapath.sv
// Datapath of the minimum-tracking stack: entry memory, cached top entry,
// minimum, stack pointer and result register. Depends on mts_pkg.
module mts_datapath
    import mts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mts_cmd_t              cmd,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [DATA_WIDTH-1:0] value,
    output logic [TDATA_W-1:0]    res_data,
    output logic [STATUS_W-1:0]   res_status
);

    logic [ENTRY_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]      sp_reg, sp_next;
    logic [DATA_WIDTH-1:0] min_reg, min_next;
    logic [ENTRY_W-1:0]    top_reg, top_next;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  refill_reg;
    logic [DATA_WIDTH-1:0] popped_reg, popped_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [TDATA_W-1:0]    res_data_reg;
    logic [STATUS_W-1:0]   res_status_reg;

    logic                      is_push, is_pop, empty, full, push_ok, pop_ok;
    logic signed [ENTRY_W-1:0] x_ext, min_ext, top_s, new_entry, restored;
    logic [ENTRY_W-1:0]        new_top;
    logic [DATA_WIDTH-1:0]     top_dec, min_out;
    logic                      res_empty;

    assign is_push = (req_type == REQ_PUSH);
    assign is_pop  = (req_type == REQ_POP);
    assign empty   = (sp_reg == '0);
    assign full    = (sp_reg == PTR_W'(DEPTH));
    assign push_ok = is_push && !full;
    assign pop_ok  = is_pop && !empty;

    assign x_ext    = ENTRY_W'(signed'(value));
    assign min_ext  = ENTRY_W'(signed'(min_reg));
    assign top_s    = signed'(top_reg);
    assign restored = (min_ext <<< 1) - top_s;

    always_comb begin
        sp_next     = sp_reg;
        min_next    = min_reg;
        top_next    = top_reg;
        popped_next = '0;
        status_next = ST_OK;
        new_entry   = x_ext;
        if (push_ok) begin
            sp_next = sp_reg + PTR_W'(1);
            if (empty) begin
                min_next = value;
            end else if (x_ext <= min_ext) begin
                // Encoded entry marks where the minimum changed.
                new_entry = (x_ext <<< 1) - min_ext;
                min_next  = value;
            end
            top_next = new_entry;
        end else if (is_push) begin
            status_next = ST_OVERFLOW;
        end else if (pop_ok) begin
            sp_next = sp_reg - PTR_W'(1);
            if (top_s <= min_ext) begin
                popped_next = min_reg;
                min_next    = restored[DATA_WIDTH-1:0];
            end else begin
                popped_next = top_reg[DATA_WIDTH-1:0];
            end
        end else if (is_pop) begin
            status_next = ST_UNDERFLOW;
        end
    end

    // Entry memory: one write for a push, one registered read for the
    // entry that becomes the top after a pop.
    always_ff @(posedge aclk) begin
        if (cmd.exec && push_ok) begin
            mem[sp_reg[ADDR_W-1:0]] <= new_entry;
        end
        if (cmd.exec && pop_ok) begin
            rd_data_reg <= mem[ADDR_W'(sp_reg - PTR_W'(2))];
        end
    end

    // Result assembled from the state after the step.
    assign new_top   = refill_reg ? rd_data_reg : top_reg;
    assign res_empty = (sp_reg == '0);

    always_comb begin
        if (res_empty) begin
            top_dec = '0;
            min_out = '0;
        end else begin
            min_out = min_reg;
            top_dec = (signed'(new_top) <= min_ext) ? min_reg : new_top[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg  <= '0;
            min_reg <= '0;
        end else if (cmd.exec) begin
            sp_reg  <= sp_next;
            min_reg <= min_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            top_reg    <= top_next;
            popped_reg <= popped_next;
            status_reg <= status_next;
            refill_reg <= pop_ok;
        end else if (cmd.finish) begin
            top_reg <= new_top;
        end
        if (cmd.finish) begin
            res_data_reg   <= TDATA_W'({res_empty, sp_reg, min_out, top_dec, popped_reg});
            res_status_reg <= status_reg;
        end
    end

    assign res_data   = res_data_reg;
    assign res_status = res_status_reg;

endmodule

>>> rtl/mts_checker.sv
// Port-level checker for the minimum-tracking stack and its bind to the top
// level. Depends on mts_pkg and min_tracking_stack_top.
module mts_checker
    import mts_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [TDATA_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    localparam int CNT_LO = 3 * DATA_WIDTH;

    logic [PTR_W-1:0] cnt;
    logic             emp;

    assign cnt = m_tdata[CNT_LO +: PTR_W];
    assign emp = m_tdata[CNT_LO + PTR_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted before the first finished");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (emp == (cnt == '0)))
        else $error("empty flag disagrees with entry count");

    // A pop that empties the stack still reports the value it removed, so only
    // the top and the minimum have to be zero on an empty stack.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && emp |-> (m_tdata[CNT_LO-1:DATA_WIDTH] == '0))
        else $error("empty stack reports a nonzero top or minimum");

    a_status_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_OVERFLOW || m_tuser == ST_UNDERFLOW) |->
            ((m_tuser == ST_OVERFLOW && cnt == PTR_W'(DEPTH)) ||
             (m_tuser == ST_UNDERFLOW && cnt == '0)))
        else $error("error status does not match entry count");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
